/* rtl/core/sgam_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgam_pkg
// Shared types and constants for the signal grid average mapper.
// ----------------------------------------------------------------------------
package sgam_pkg;

    localparam int GRID_WIDTH  = 256;
    localparam int GRID_HEIGHT = 256;
    localparam int GRID_CELLS  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W      = $clog2(GRID_CELLS);

    localparam int CENTRE_COL = ((GRID_WIDTH / 2) > 128) ? 128 : (GRID_WIDTH / 2);
    localparam int CENTRE_ROW = ((GRID_HEIGHT / 2) > 128) ? 128 : (GRID_HEIGHT / 2);

    localparam logic [7:0] BOX_MIN_COL_RST = 8'(CENTRE_COL - 1);
    localparam logic [7:0] BOX_MIN_ROW_RST = 8'(CENTRE_ROW - 1);
    localparam logic [7:0] BOX_MAX_COL_RST = 8'(CENTRE_COL + 2);
    localparam logic [7:0] BOX_MAX_ROW_RST = 8'(CENTRE_ROW + 2);

    localparam logic [7:0]  LEVEL_FULL   = 8'd254;
    localparam logic [7:0]  COUNT_FULL   = 8'd255;
    localparam logic [15:0] PEAK_RST     = 16'd410;
    localparam logic [31:0] Q8_SCALE     = 32'(254 * 256);

    localparam int DIVD_W = 32;
    localparam int DIVS_W = 16;
    localparam int DIV_STEPS_W = $clog2(DIVD_W);

    typedef enum logic [1:0] {
        DIV_SWEEP,
        DIV_Q8,
        DIV_MEAN
    } div_sel_t;

    typedef struct packed {
        logic [7:0]  cell_column;
        logic [7:0]  cell_row;
        logic [15:0] signal_value;
    } in_t;

    typedef struct packed {
        logic [7:0] cell_level;
        logic [7:0] cell_count;
        logic       rescaled;
        logic [7:0] box_left;
        logic [7:0] box_top;
        logic [7:0] box_right;
        logic [7:0] box_bottom;
    } out_t;

    typedef struct packed {
        logic     ld_in;
        logic     chk;
        logic     addr_clr;
        logic     addr_inc;
        logic     sel_sweep;
        logic     clr_we;
        logic     sw_write;
        logic     div_start;
        div_sel_t div_sel;
        logic     ld_q8;
        logic     ld_lvl_direct;
        logic     ld_lvl_div;
        logic     fin;
    } cmd_t;

    typedef struct packed {
        logic addr_last;
        logic raise;
        logic lvl_zero;
        logic cnt_zero;
        logic div_done;
        logic out_busy;
    } sts_t;

endpackage

/* rtl/core/signal_grid_average_mapper_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signal_grid_average_mapper_top
// Running-mean signal map over a 256 x 256 grid with peak normalization.
// ----------------------------------------------------------------------------
// After reset the block clears all 65536 cells of the level and count
// memories, one cell per cycle, and accepts no word until that pass ends; the
// peak register may be written meanwhile. An ordinary word is then compared
// against the peak and goes through two passes of the shared bit-serial
// divider (the sample scaling and the running mean; the second is skipped
// for a cell seen for the first time). A word whose magnitude exceeds the
// peak first sweeps the whole level memory, which skips each zero cell and
// runs one divide for each nonzero cell. A finished result sits in an output
// register until taken, and the next word is accepted meanwhile.
// ----------------------------------------------------------------------------
module signal_grid_average_mapper_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [15:0]    cfg_wr_data,
    input  logic           s_valid,
    output logic           s_ready,
    input  sgam_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sgam_pkg::out_t m_data
);

    // Commands from the sequencer and status back from the datapath.
    sgam_pkg::cmd_t cmd;
    sgam_pkg::sts_t sts;

    sgam_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // The datapath holds both grid memories, the peak, the box and the
    // result register.
    sgam_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_data      (m_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

/* rtl/core/sgam_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sgam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/sgam_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgam_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sgam_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [sgam_pkg::DIVD_W-1:0] dividend,
    input  logic [sgam_pkg::DIVS_W-1:0] divisor,
    output logic                        done,
    output logic [sgam_pkg::DIVD_W-1:0] quotient
);

    logic [sgam_pkg::DIVS_W-1:0]      rem_reg;
    logic [sgam_pkg::DIVD_W-1:0]      quo_reg;
    logic [sgam_pkg::DIVS_W-1:0]      dvs_reg;
    logic [sgam_pkg::DIV_STEPS_W-1:0] cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [sgam_pkg::DIVS_W:0]        trial;
    logic                             fits;

    assign trial = {rem_reg, quo_reg[sgam_pkg::DIVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? sgam_pkg::DIVS_W'(trial - {1'b0, dvs_reg})
                                : sgam_pkg::DIVS_W'(trial);
                quo_reg <= {quo_reg[sgam_pkg::DIVD_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == sgam_pkg::DIV_STEPS_W'(sgam_pkg::DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/sgam_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgam_dp
// Datapath: grid memories, peak and box registers, divider, result register.
// ----------------------------------------------------------------------------
module sgam_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  sgam_pkg::in_t     s_data,
    output sgam_pkg::out_t    m_data,
    output logic              m_valid,
    input  logic              m_ready,
    input  sgam_pkg::cmd_t    cmd,
    output sgam_pkg::sts_t    sts
);

    logic [15:0]                 peak_reg;
    logic [15:0]                 old_peak_reg;
    logic [15:0]                 mag_reg;
    logic [7:0]                  col_reg;
    logic [7:0]                  row_reg;
    logic [sgam_pkg::ADDR_W-1:0] idx_reg;
    logic [sgam_pkg::ADDR_W-1:0] addr_reg;
    logic                        rescaled_reg;
    logic [15:0]                 q8_reg;
    logic [7:0]                  level_new_reg;
    logic [7:0]                  box_l_reg, box_t_reg, box_r_reg, box_b_reg;
    logic [7:0]                  box_l_next, box_t_next, box_r_next, box_b_next;
    sgam_pkg::out_t              out_reg;
    logic                        m_valid_reg;

    logic [15:0]                 raw;
    logic [15:0]                 mag_in;
    logic [7:0]                  col_sat, row_sat;
    logic [15:0]                 peak_nz;
    logic [7:0]                  lvl_rd, cnt_rd, cnt_new;
    logic [sgam_pkg::ADDR_W-1:0] ram_addr;
    logic [sgam_pkg::DIVD_W-1:0] div_dividend, div_q;
    logic [sgam_pkg::DIVS_W-1:0] div_divisor;
    logic                        div_done;
    logic                        lvl_we, cnt_we;
    logic [7:0]                  lvl_wdata, cnt_wdata;

    assign raw     = s_data.signal_value;
    assign mag_in  = raw[15] ? 16'(17'h10000 - {1'b0, raw}) : raw;
    assign col_sat = (32'(s_data.cell_column) >= sgam_pkg::GRID_WIDTH)
                   ? 8'(sgam_pkg::GRID_WIDTH - 1) : s_data.cell_column;
    assign row_sat = (32'(s_data.cell_row) >= sgam_pkg::GRID_HEIGHT)
                   ? 8'(sgam_pkg::GRID_HEIGHT - 1) : s_data.cell_row;
    assign peak_nz = (peak_reg == 16'd0) ? 16'd1 : peak_reg;

    assign ram_addr = cmd.sel_sweep ? addr_reg : idx_reg;

    // The clearing pass zeroes both memories so that the sweep skips every
    // cell that has never been visited.
    assign lvl_we    = cmd.clr_we | cmd.sw_write | cmd.fin;
    assign lvl_wdata = cmd.clr_we ? 8'd0 : (cmd.sw_write ? div_q[7:0] : level_new_reg);
    assign cnt_we    = cmd.clr_we | cmd.fin;
    assign cnt_wdata = cmd.clr_we ? 8'd0 : cnt_new;
    assign cnt_new   = (cnt_rd == sgam_pkg::COUNT_FULL) ? cnt_rd : cnt_rd + 8'd1;

    sgam_ram #(.WIDTH(8), .DEPTH(sgam_pkg::GRID_CELLS)) u_level_ram (
        .aclk  (aclk),
        .we    (lvl_we),
        .waddr (ram_addr),
        .wdata (lvl_wdata),
        .raddr (ram_addr),
        .rdata (lvl_rd)
    );

    sgam_ram #(.WIDTH(8), .DEPTH(sgam_pkg::GRID_CELLS)) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (ram_addr),
        .wdata (cnt_wdata),
        .raddr (ram_addr),
        .rdata (cnt_rd)
    );

    always_comb begin
        case (cmd.div_sel)
            sgam_pkg::DIV_SWEEP: begin
                div_dividend = 32'(lvl_rd) * 32'(old_peak_reg);
                div_divisor  = peak_reg;
            end
            sgam_pkg::DIV_Q8: begin
                div_dividend = sgam_pkg::Q8_SCALE * 32'(mag_reg);
                div_divisor  = peak_reg;
            end
            sgam_pkg::DIV_MEAN: begin
                div_dividend = 32'(lvl_rd) * 32'(cnt_rd) + 32'(q8_reg[15:8]);
                div_divisor  = 16'(cnt_rd) + 16'd1;
            end
            default: begin
                div_dividend = '0;
                div_divisor  = 16'd1;
            end
        endcase
    end

    sgam_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // A cell left of the box moves the left edge but not the right, and so on.
    always_comb begin
        box_l_next = box_l_reg;
        box_r_next = box_r_reg;
        box_t_next = box_t_reg;
        box_b_next = box_b_reg;
        if (box_l_reg > col_reg) begin
            box_l_next = col_reg;
        end else if (box_r_reg < col_reg) begin
            box_r_next = col_reg;
        end
        if (box_t_reg > row_reg) begin
            box_t_next = row_reg;
        end else if (box_b_reg < row_reg) begin
            box_b_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg    <= sgam_pkg::PEAK_RST;
            box_l_reg   <= sgam_pkg::BOX_MIN_COL_RST;
            box_t_reg   <= sgam_pkg::BOX_MIN_ROW_RST;
            box_r_reg   <= sgam_pkg::BOX_MAX_COL_RST;
            box_b_reg   <= sgam_pkg::BOX_MAX_ROW_RST;
            addr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                peak_reg <= cfg_wr_data;
            end
            if (cmd.ld_in) begin
                col_reg <= col_sat;
                row_reg <= row_sat;
                mag_reg <= mag_in;
                idx_reg <= sgam_pkg::ADDR_W'(32'(row_sat) * sgam_pkg::GRID_WIDTH
                                             + 32'(col_sat));
            end
            if (cmd.chk) begin
                old_peak_reg <= peak_nz;
                rescaled_reg <= mag_reg > peak_nz;
                peak_reg     <= (mag_reg > peak_nz) ? mag_reg : peak_nz;
            end
            if (cmd.addr_clr) begin
                addr_reg <= '0;
            end else if (cmd.addr_inc) begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (cmd.ld_q8) begin
                q8_reg <= div_q[15:0];
            end
            if (cmd.ld_lvl_direct) begin
                level_new_reg <= q8_reg[15:8];
            end else if (cmd.ld_lvl_div) begin
                level_new_reg <= (div_q > 32'(sgam_pkg::LEVEL_FULL))
                               ? sgam_pkg::LEVEL_FULL : div_q[7:0];
            end
            if (cmd.fin) begin
                box_l_reg <= box_l_next;
                box_t_reg <= box_t_next;
                box_r_reg <= box_r_next;
                box_b_reg <= box_b_next;
                out_reg.cell_level <= level_new_reg;
                out_reg.cell_count <= cnt_new;
                out_reg.rescaled   <= rescaled_reg;
                out_reg.box_left   <= box_l_next;
                out_reg.box_top    <= box_t_next;
                out_reg.box_right  <= box_r_next;
                out_reg.box_bottom <= box_b_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

    assign sts.addr_last = addr_reg == sgam_pkg::ADDR_W'(sgam_pkg::GRID_CELLS - 1);
    assign sts.raise     = mag_reg > peak_nz;
    assign sts.lvl_zero  = lvl_rd == 8'd0;
    assign sts.cnt_zero  = cnt_rd == 8'd0;
    assign sts.div_done  = div_done;
    assign sts.out_busy  = m_valid_reg & ~m_ready;

endmodule

/* rtl/core/sgam_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgam_ctrl
// Sequencer for the clearing pass, the rescale sweep and the item update.
// ----------------------------------------------------------------------------
module sgam_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output sgam_pkg::cmd_t cmd,
    input  sgam_pkg::sts_t sts
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SRD,
        ST_SCHK,
        ST_SDIV,
        ST_IRD,
        ST_IQ8,
        ST_IMEAN,
        ST_IMW,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = sgam_pkg::DIV_SWEEP;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.sel_sweep = 1'b1;
                cmd.clr_we    = 1'b1;
                cmd.addr_inc  = 1'b1;
                if (sts.addr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.addr_clr = 1'b1;
                if (s_valid) begin
                    cmd.ld_in  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.chk    = 1'b1;
                state_next = sts.raise ? ST_SRD : ST_IRD;
            end
            ST_SRD: begin
                cmd.sel_sweep = 1'b1;
                state_next    = ST_SCHK;
            end
            ST_SCHK: begin
                cmd.sel_sweep = 1'b1;
                if (sts.lvl_zero) begin
                    cmd.addr_inc = 1'b1;
                    state_next   = sts.addr_last ? ST_IRD : ST_SRD;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = sgam_pkg::DIV_SWEEP;
                    state_next    = ST_SDIV;
                end
            end
            ST_SDIV: begin
                cmd.sel_sweep = 1'b1;
                if (sts.div_done) begin
                    cmd.sw_write = 1'b1;
                    cmd.addr_inc = 1'b1;
                    state_next   = sts.addr_last ? ST_IRD : ST_SRD;
                end
            end
            ST_IRD: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = sgam_pkg::DIV_Q8;
                state_next    = ST_IQ8;
            end
            ST_IQ8: begin
                if (sts.div_done) begin
                    cmd.ld_q8  = 1'b1;
                    state_next = ST_IMEAN;
                end
            end
            ST_IMEAN: begin
                if (sts.cnt_zero) begin
                    cmd.ld_lvl_direct = 1'b1;
                    state_next        = ST_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = sgam_pkg::DIV_MEAN;
                    state_next    = ST_IMW;
                end
            end
            ST_IMW: begin
                if (sts.div_done) begin
                    cmd.ld_lvl_div = 1'b1;
                    state_next     = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!sts.out_busy) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/sgam_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgam_checker
// Port-level checks on the result channel of the mapper.
// ----------------------------------------------------------------------------
module sgam_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input sgam_pkg::out_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.cell_count != 8'd0 && m_data.cell_level <= 8'd254)
        else $error("cell level or count out of range");

    a_box: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.box_left <= m_data.box_right
                    && m_data.box_top <= m_data.box_bottom)
        else $error("explored box edges crossed");

endmodule

bind signal_grid_average_mapper_top sgam_checker u_sgam_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
